@@ sv/serl_pkg.sv @@
// Shared constants and types for the sensor edge recent-list block.
// Used by serl_front, serl_fifo, serl_back and sensor_edge_recent_list.
package serl_pkg;

  localparam int NUM_MODULES = 5;
  localparam int LIST_DEPTH  = 8;
  localparam int SCAN_BYTES  = NUM_MODULES * 2;
  localparam int SB_W        = $clog2(SCAN_BYTES);
  localparam int IDX_W       = 4;
  localparam int ID_W        = 7;
  localparam int TIME_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W       = $clog2(LIST_DEPTH + BYTE_W + 1);
  localparam int POS_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int Q_DEPTH     = 4;
  localparam int QP_W        = $clog2(Q_DEPTH);
  localparam int QC_W        = $clog2(Q_DEPTH + 1);
  localparam int S_DATA_W    = 48;
  localparam int M_DATA_W    = 40;

  // Classified scan byte handed from the front to the back
  typedef struct packed {
    logic [BYTE_W-1:0] rise;
    logic [IDX_W-1:0]  idx;
    logic              scan_end;
    logic [TIME_W-1:0] scan_time;
  } edge_word_t;

  // Queue status seen by the producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ sv/serl_front.sv @@
// Front end: keeps the previous scan and finds rising bits of each byte.
// Depends on serl_pkg.
module serl_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [serl_pkg::BYTE_W-1:0] sensor_byte,
  input  logic [serl_pkg::IDX_W-1:0]  byte_index,
  input  logic                       scan_end,
  input  logic [serl_pkg::TIME_W-1:0] scan_time,
  output serl_pkg::edge_word_t       word
);

  logic [serl_pkg::BYTE_W-1:0] prev_scan [serl_pkg::SCAN_BYTES];
  logic                        in_range;
  logic [serl_pkg::SB_W-1:0]   slot;
  logic [serl_pkg::BYTE_W-1:0] old_byte;

  // out-of-range bytes are neither compared nor stored
  assign in_range = {1'b0, byte_index} < (serl_pkg::IDX_W + 1)'(serl_pkg::SCAN_BYTES);
  assign slot     = byte_index[serl_pkg::SB_W-1:0];
  assign old_byte = prev_scan[slot];

  // classify: rising bits and pass-through fields
  always_comb begin
    word.rise      = in_range ? (sensor_byte & ~old_byte) : '0;
    word.idx       = byte_index;
    word.scan_end  = scan_end;
    word.scan_time = scan_time;
  end

  // previous scan starts all ones so the first scan sees no edges
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < serl_pkg::SCAN_BYTES; i++) begin
        prev_scan[i] <= '1;
      end
    end else if (take && in_range) begin
      prev_scan[slot] <= sensor_byte;
    end
  end

endmodule

@@ sv/serl_fifo.sv @@
// Short queue between the front and the back end.
// Depends on serl_pkg.
module serl_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  serl_pkg::edge_word_t push_word,
  input  logic                 pop,
  output serl_pkg::edge_word_t head,
  output serl_pkg::q_status_t  status
);

  serl_pkg::edge_word_t          mem [serl_pkg::Q_DEPTH];
  logic [serl_pkg::QP_W-1:0]     wr_ptr;
  logic [serl_pkg::QP_W-1:0]     rd_ptr;
  logic [serl_pkg::QC_W-1:0]     fill;

  assign head         = mem[rd_ptr];
  assign status.full  = fill == serl_pkg::QC_W'(serl_pkg::Q_DEPTH);
  assign status.empty = fill == '0;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (!push && pop) fill <= fill - 1'b1;
    end
  end

endmodule

@@ sv/serl_back.sv @@
// Back end: pushes edges onto the recent list and streams out reports.
// Depends on serl_pkg.
module serl_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  serl_pkg::edge_word_t        head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [serl_pkg::ID_W-1:0]   sensor_id,
  output logic                        entry_valid,
  output logic [serl_pkg::TIME_W-1:0] report_time,
  output logic                        run_last
);

  logic [serl_pkg::ID_W-1:0]  list [serl_pkg::LIST_DEPTH];
  logic [serl_pkg::CNT_W-1:0] count;
  logic [serl_pkg::ID_W-1:0]  list_next [serl_pkg::LIST_DEPTH];
  logic [serl_pkg::CNT_W-1:0] count_next;
  logic [serl_pkg::SUM_W-1:0] sum;

  logic [serl_pkg::ID_W-1:0]   rep_list [serl_pkg::LIST_DEPTH];
  logic [serl_pkg::CNT_W-1:0]  rep_count;
  logic [serl_pkg::TIME_W-1:0] rep_time;
  logic                        rep_busy;
  logic [serl_pkg::POS_W-1:0]  rep_pos;

  logic need_report;
  logic rep_last;
  logic rep_hold;
  logic pos_in_count;

  // push rising bits, MSB first, each onto the front of the list
  always_comb begin
    for (int j = 0; j < serl_pkg::LIST_DEPTH; j++) begin
      list_next[j] = list[j];
    end
    sum = serl_pkg::SUM_W'(count);
    for (int k = 0; k < serl_pkg::BYTE_W; k++) begin
      if (head.rise[serl_pkg::BYTE_W-1-k]) begin
        for (int j = serl_pkg::LIST_DEPTH - 1; j > 0; j--) begin
          list_next[j] = list_next[j-1];
        end
        list_next[0] = {head.idx, 3'(k)};
        sum = sum + 1'b1;
      end
    end
    // count saturates at the list depth
    if (sum > serl_pkg::SUM_W'(serl_pkg::LIST_DEPTH)) begin
      count_next = serl_pkg::CNT_W'(serl_pkg::LIST_DEPTH);
    end else begin
      count_next = sum[serl_pkg::CNT_W-1:0];
    end
  end

  // a report may load once the current one hands over its last word
  assign rep_last    = rep_pos == serl_pkg::POS_W'(serl_pkg::LIST_DEPTH - 1);
  assign rep_hold    = rep_busy && !(out_ready && rep_last);
  assign need_report = head.scan_end && (count_next != '0);
  assign pop         = head_valid && !(need_report && rep_hold);

  // working list
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int j = 0; j < serl_pkg::LIST_DEPTH; j++) begin
        list[j] <= '0;
      end
    end else if (pop) begin
      for (int j = 0; j < serl_pkg::LIST_DEPTH; j++) begin
        list[j] <= list_next[j];
      end
      count <= need_report ? '0 : count_next;
    end
  end

  // report buffer snapshot
  always_ff @(posedge clk) begin
    if (pop && need_report) begin
      for (int j = 0; j < serl_pkg::LIST_DEPTH; j++) begin
        rep_list[j] <= list_next[j];
      end
      rep_count <= count_next;
      rep_time  <= head.scan_time;
    end
  end

  // report sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_busy <= 1'b0;
      rep_pos  <= '0;
    end else if (pop && need_report) begin
      rep_busy <= 1'b1;
      rep_pos  <= '0;
    end else if (rep_busy && out_ready) begin
      if (rep_last) begin
        rep_busy <= 1'b0;
      end else begin
        rep_pos <= rep_pos + 1'b1;
      end
    end
  end

  // output word
  assign pos_in_count = (serl_pkg::SUM_W)'(rep_pos) < (serl_pkg::SUM_W)'(rep_count);
  assign out_valid    = rep_busy;
  assign entry_valid  = pos_in_count;
  assign sensor_id    = pos_in_count ? rep_list[rep_pos] : '0;
  assign report_time  = rep_time;
  assign run_last     = rep_last;

endmodule

@@ sv/sensor_edge_recent_list.sv @@
// Rising-edge detector over a scanned sensor array with a list of the most
// recently triggered sensors. A byte is taken in every cycle while the
// four-word queue behind the front end has room; its rising bits are pushed
// onto the list by the back end. A report is eight words, one
// per cycle the output is ready, streamed from a snapshot buffer, so the
// list keeps taking edges meanwhile; the back end stalls only when a second
// report is due before the first has left. Previous-scan bytes reset to all
// ones, so the first scan after reset reports nothing. No clearing pass.
// Depends on serl_pkg, serl_front, serl_fifo and serl_back.
module sensor_edge_recent_list (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [7:0] sensor_byte, [11:8] byte_index, [43:12] scan_time, rest zero
  input  logic [serl_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [6:0] sensor_id, [38:7] report_time, rest zero
  output logic [serl_pkg::M_DATA_W-1:0] m_tdata,
  // [0] entry_valid
  output logic [0:0]                    m_tuser,
  output logic                          m_tlast
);

  logic                        take;
  serl_pkg::edge_word_t        front_word;
  serl_pkg::edge_word_t        head;
  serl_pkg::q_status_t         q_status;
  logic                        pop;
  logic [serl_pkg::ID_W-1:0]   sensor_id;
  logic                        entry_valid;
  logic [serl_pkg::TIME_W-1:0] report_time;

  assign s_tready = !q_status.full;
  assign take     = s_tvalid && s_tready;

  serl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .sensor_byte (s_tdata[7:0]),
    .byte_index  (s_tdata[11:8]),
    .scan_end    (s_tlast),
    .scan_time   (s_tdata[43:12]),
    .word        (front_word)
  );

  serl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_word (front_word),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  serl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!q_status.empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .sensor_id   (sensor_id),
    .entry_valid (entry_valid),
    .report_time (report_time),
    .run_last    (m_tlast)
  );

  // pack output word
  assign m_tdata = {{(serl_pkg::M_DATA_W - serl_pkg::TIME_W - serl_pkg::ID_W){1'b0}},
                    report_time, sensor_id};
  assign m_tuser = entry_valid;

  // a new report always opens with a valid entry
  a_report_opens_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || m_tuser[0]))
    else $error("report does not open with a valid entry");

  // valid entries form a prefix of the report
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tuser[0] && !m_tlast) |=> (m_tvalid && !m_tuser[0]))
    else $error("valid entry after an invalid one");

  // invalid entries carry a zero id
  a_invalid_zero_id: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[6:0] == '0))
    else $error("invalid entry with nonzero id");

endmodule

@@ tb/sensor_edge_recent_list_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for sensor_edge_recent_list: streams scan bytes,
// predicts each list report in-line and checks every output word in order.
// Depends on serl_pkg and the sensor_edge_recent_list RTL.
module sensor_edge_recent_list_tb;
  import serl_pkg::*;

  // One scan byte as offered on the input stream
  typedef struct {
    logic [BYTE_W-1:0] sensor_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              scan_end;
    logic [TIME_W-1:0] scan_time;
  } scan_word_t;

  // One list entry as expected on the output stream
  typedef struct {
    logic [ID_W-1:0]   sensor_id;
    logic              entry_valid;
    logic [TIME_W-1:0] report_time;
    logic              run_last;
  } list_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;

  scan_word_t            pending_scan_q[$];
  list_word_t            expected_list_q[$];
  scan_word_t            held_word;
  list_word_t            got_word;
  list_word_t            want_word;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    mismatch_cnt = 0;

  // Predictor state
  logic [BYTE_W-1:0]     last_scan_bytes[SCAN_BYTES];
  logic [ID_W-1:0]       recent_ids[LIST_DEPTH];
  int                    new_edge_cnt;

  // Stimulus helper: last byte generated per position, for sparse changes
  logic [BYTE_W-1:0]     gen_bytes[SCAN_BYTES];

  sensor_edge_recent_list dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // Apply one accepted scan byte to the predictor; queue any report it causes
  task automatic track_edges(input scan_word_t w);
    logic [BYTE_W-1:0] rise;
    list_word_t        r;
    int                k;
    int                l;
    if (w.byte_index < SCAN_BYTES) begin
      rise = w.sensor_byte & ~last_scan_bytes[w.byte_index];
      // MSB first, newest edge goes to the head of the list
      for (k = 0; k < BYTE_W; k++) begin
        if (rise[BYTE_W-1-k]) begin
          for (l = LIST_DEPTH - 1; l > 0; l--) recent_ids[l] = recent_ids[l-1];
          recent_ids[0] = ID_W'(w.byte_index * BYTE_W + k);
          if (new_edge_cnt < LIST_DEPTH) new_edge_cnt++;
        end
      end
      last_scan_bytes[w.byte_index] = w.sensor_byte;
    end
    if (w.scan_end && new_edge_cnt > 0) begin
      for (k = 0; k < LIST_DEPTH; k++) begin
        r.entry_valid = (k < new_edge_cnt);
        r.sensor_id   = r.entry_valid ? recent_ids[k] : '0;
        r.report_time = w.scan_time;
        r.run_last    = (k == LIST_DEPTH - 1);
        expected_list_q.push_back(r);
      end
      new_edge_cnt = 0;
    end
  endtask

  task automatic add_word(input logic [BYTE_W-1:0] b, input logic [IDX_W-1:0] idx,
                          input logic last, input logic [TIME_W-1:0] t);
    scan_word_t w;
    w.sensor_byte = b;
    w.byte_index  = idx;
    w.scan_end    = last;
    w.scan_time   = t;
    pending_scan_q.push_back(w);
  endtask

  // Directed words: field extremes and the corner cases of the edge list
  task automatic add_directed();
    // first scan after reset sees no edges, so no report
    add_word(8'hFF, 4'd0, 1'b1, 32'h0000_0000);
    // full byte of edges, max timestamp
    add_word(8'h00, 4'd0, 1'b0, 32'h0000_0000);
    add_word(8'hFF, 4'd0, 1'b1, 32'hFFFF_FFFF);
    // two edges: outermost bits of byte 1
    add_word(8'h00, 4'd1, 1'b0, 32'h0);
    add_word(8'h81, 4'd1, 1'b1, 32'h1234_5678);
    // out-of-range index is ignored, scan end with no edges gives nothing
    add_word(8'hFF, 4'd15, 1'b1, 32'hAAAA_5555);
    add_word(8'h00, 4'd10, 1'b0, 32'h0);
    // edges on the last valid byte, report raised by an out-of-range word
    add_word(8'h00, 4'd9, 1'b0, 32'h0);
    add_word(8'hFF, 4'd9, 1'b0, 32'h0);
    add_word(8'h55, 4'd12, 1'b1, 32'h5555_AAAA);
    // end of scan with no edges
    add_word(8'h00, 4'd2, 1'b0, 32'h0);
    add_word(8'h00, 4'd2, 1'b1, 32'h8000_0001);
    // sixteen rising bits over two bytes: count saturates at list depth
    add_word(8'h00, 4'd3, 1'b0, 32'h0);
    add_word(8'h00, 4'd4, 1'b0, 32'h0);
    add_word(8'hFF, 4'd3, 1'b0, 32'h0);
    add_word(8'hFF, 4'd4, 1'b1, 32'h7FFF_FFFF);
    // edges accumulate across words before the scan end
    add_word(8'h00, 4'd5, 1'b0, 32'h0);
    add_word(8'h01, 4'd5, 1'b0, 32'h0);
    add_word(8'h00, 4'd8, 1'b0, 32'h0);
    add_word(8'h80, 4'd8, 1'b0, 32'h0);
    add_word(8'h00, 4'd6, 1'b1, 32'h0F0F_F0F0);
  endtask

  // One full scan with random content, some noise and the odd early end
  task automatic add_scan();
    int                kind;
    int                i;
    logic [BYTE_W-1:0] b;
    logic [TIME_W-1:0] t;
    logic              last;
    kind = $urandom_range(2);
    t    = $urandom;
    for (i = 0; i < SCAN_BYTES; i++) begin
      if ($urandom_range(9) == 0)
        add_word(BYTE_W'($urandom), IDX_W'($urandom_range(15)), 1'($urandom_range(1)),
                 $urandom);
      case (kind)
        0: b = BYTE_W'($urandom);
        1: b = ($urandom_range(3) == 0) ? gen_bytes[i] ^ (8'h01 << $urandom_range(7))
                                        : gen_bytes[i];
        default: b = $urandom_range(1) ? 8'h00 : BYTE_W'($urandom);
      endcase
      last = (i == SCAN_BYTES - 1) || ($urandom_range(39) == 0);
      add_word(b, IDX_W'(i), last, t);
      gen_bytes[i] = b;
    end
  endtask

  // Input driver: holds a word until it is taken, then maybe idles
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) track_edges(held_word);
      if (!s_tvalid || s_tready) begin
        if (pending_scan_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_word = pending_scan_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {4'b0, held_word.scan_time, held_word.byte_index,
                       held_word.sensor_byte};
          s_tlast  <= held_word.scan_end;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random backpressure, in-order compare of each word
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_word.sensor_id   = m_tdata[ID_W-1:0];
        got_word.report_time = m_tdata[ID_W+TIME_W-1:ID_W];
        got_word.entry_valid = m_tuser[0];
        got_word.run_last    = m_tlast;
        if (expected_list_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word id=%0d valid=%0b time=%h last=%0b",
                                    got_word.sensor_id, got_word.entry_valid,
                                    got_word.report_time, got_word.run_last));
        end else begin
          want_word = expected_list_q.pop_front();
          if (got_word.sensor_id !== want_word.sensor_id)
            report_mismatch($sformatf("sensor_id %0d, want %0d",
                                      got_word.sensor_id, want_word.sensor_id));
          if (got_word.entry_valid !== want_word.entry_valid)
            report_mismatch($sformatf("entry_valid %0b, want %0b",
                                      got_word.entry_valid, want_word.entry_valid));
          if (got_word.report_time !== want_word.report_time)
            report_mismatch($sformatf("report_time %h, want %h",
                                      got_word.report_time, want_word.report_time));
          if (got_word.run_last !== want_word.run_last)
            report_mismatch($sformatf("run_last %0b, want %0b",
                                      got_word.run_last, want_word.run_last));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sequencer: reset, then four phases of idle and stall mixes, each drained before the next
  initial begin
    int phase;
    for (int i = 0; i < SCAN_BYTES; i++) begin
      last_scan_bytes[i] = '1;
      gen_bytes[i]       = '1;
    end
    for (int i = 0; i < LIST_DEPTH; i++) recent_ids[i] = '0;
    new_edge_cnt = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (phase == 0) add_directed();
      repeat (8) add_scan();
      // wait until every word is sent and every report of this phase has come back
      while (pending_scan_q.size() != 0 || s_tvalid || expected_list_q.size() != 0)
        @(negedge clk);
    end
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
